/* rtl/ise_pkg.sv */
// ----------------------------------------------------------------------------
// ise_pkg
// shared sizes, types and sequencer states of the insertion sort engine
// ----------------------------------------------------------------------------
package ise_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;

	typedef logic [ADDR_W-1:0]        addr_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_KEY,
		ST_FIRST,
		ST_SCAN,
		ST_PLACE,
		ST_EMIT
	} state_t;

endpackage

/* rtl/ise_intf.sv */
// ----------------------------------------------------------------------------
// ise_intf
// valid/ready channels of the insertion sort engine: input items and results
// ----------------------------------------------------------------------------
interface ise_item_if;
	logic            valid;
	logic            ready;
	ise_pkg::data_t  value;
	logic            last;

	modport source (output valid, value, last, input ready);
	modport sink   (input valid, value, last, output ready);
endinterface

interface ise_result_if;
	logic            valid;
	logic            ready;
	ise_pkg::data_t  sorted_value;
	logic            final_res;
	logic            overflow;

	modport source (output valid, sorted_value, final_res, overflow, input ready);
	modport sink   (input valid, sorted_value, final_res, overflow, output ready);
endinterface

/* rtl/ise_ram.sv */
// ----------------------------------------------------------------------------
// ise_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ise_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/insertion_sort_engine.sv */
// ----------------------------------------------------------------------------
// insertion_sort_engine
// collects a set of signed values, sorts it in place by insertion sort and
// streams it out in ascending order
// ----------------------------------------------------------------------------
// Items enter on the items channel, one signed 32-bit value per transaction,
// one per cycle while loading; last closes the set. Up to CAPACITY values are
// kept in a single element ram (one write port, one registered read port);
// values beyond that are dropped and every result of the set then has
// overflow set. After the last item the ram is sorted in place: for each key
// the key is fetched, then its left neighbor, then each larger neighbor is
// shifted one entry right until the key settles, the single read port
// walking the ram. The set is then read back through an output register, a
// new entry being read only once the previous one has landed there; the last
// result carries final_res. Items are not taken while sorting or reading
// back, but loading of the next set starts while the final result still
// waits in the output register. The ram needs no clearing pass: only entries
// written in the current set are read.
// ----------------------------------------------------------------------------
module insertion_sort_engine (
	input  logic                clk,
	input  logic                arst_n,
	ise_item_if.sink            items,
	ise_result_if.source        results
);

	ise_pkg::state_t state_q, state_d;

	ise_pkg::addr_t  i_q;        // index of the key being inserted
	ise_pkg::addr_t  pos_q;      // hole the key may drop into
	ise_pkg::addr_t  e_q;        // next entry to read back
	ise_pkg::data_t  key_q;
	ise_pkg::cnt_t   count_q;    // values held in the current set
	logic            dropped_q;
	logic            pend_q;     // read-back data lands this cycle

	// output register
	logic            out_valid_q;
	ise_pkg::data_t  sorted_q;
	logic            final_q;
	logic            overflow_q;

	// ram port
	logic            we, re;
	ise_pkg::addr_t  waddr, raddr;
	ise_pkg::data_t  wdata;
	logic [ise_pkg::DATA_W-1:0] rdata_raw;
	ise_pkg::data_t  rdata;

	logic            accept;
	logic            has_room;
	ise_pkg::cnt_t   n_next;
	logic            greater;
	logic            more;
	logic            issue;
	logic            land_final;

	assign rdata    = ise_pkg::data_t'(rdata_raw);
	assign accept   = items.valid && items.ready;
	assign has_room = count_q < ise_pkg::cnt_t'(ise_pkg::CAPACITY);
	assign n_next   = has_room ? count_q + ise_pkg::cnt_t'(1) : count_q;
	// signed compare keeps ascending two's complement order
	assign greater  = rdata > key_q;
	assign more     = (ise_pkg::cnt_t'(i_q) + ise_pkg::cnt_t'(1)) < count_q;
	// fetch the next result only when the output slot is free on arrival
	assign issue    = (state_q == ise_pkg::ST_EMIT) && !pend_q &&
	                  (!out_valid_q || results.ready);
	assign land_final = pend_q &&
	                    (ise_pkg::cnt_t'(e_q) == count_q - ise_pkg::cnt_t'(1));

	assign items.ready          = (state_q == ise_pkg::ST_LOAD);
	assign results.valid        = out_valid_q;
	assign results.sorted_value = sorted_q;
	assign results.final_res    = final_q;
	assign results.overflow     = overflow_q;

	ise_ram #(
		.WIDTH (ise_pkg::DATA_W),
		.DEPTH (ise_pkg::CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata_raw)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ise_pkg::ST_LOAD: begin
				if (accept && items.last) begin
					state_d = (n_next > ise_pkg::cnt_t'(1)) ? ise_pkg::ST_KEY
					                                        : ise_pkg::ST_EMIT;
				end
			end
			ise_pkg::ST_KEY: begin
				state_d = ise_pkg::ST_FIRST;
			end
			ise_pkg::ST_FIRST: begin
				state_d = ise_pkg::ST_SCAN;
			end
			ise_pkg::ST_SCAN: begin
				if (greater) begin
					state_d = (pos_q == ise_pkg::addr_t'(1)) ? ise_pkg::ST_PLACE
					                                        : ise_pkg::ST_SCAN;
				end else begin
					state_d = more ? ise_pkg::ST_FIRST : ise_pkg::ST_EMIT;
				end
			end
			ise_pkg::ST_PLACE: begin
				state_d = more ? ise_pkg::ST_FIRST : ise_pkg::ST_EMIT;
			end
			ise_pkg::ST_EMIT: begin
				if (land_final) begin
					state_d = ise_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = ise_pkg::ST_LOAD;
			end
		endcase
	end

	// ram control: reads and write-backs never touch the same entry together
	always_comb begin
		we    = 1'b0;
		waddr = count_q[ise_pkg::ADDR_W-1:0];
		wdata = items.value;
		re    = 1'b0;
		raddr = i_q;
		case (state_q)
			ise_pkg::ST_LOAD: begin
				we = accept && has_room;
			end
			ise_pkg::ST_KEY: begin
				re    = 1'b1;
				raddr = i_q;
			end
			ise_pkg::ST_FIRST: begin
				re    = 1'b1;
				raddr = i_q - ise_pkg::addr_t'(1);
			end
			ise_pkg::ST_SCAN: begin
				we    = 1'b1;
				waddr = pos_q;
				if (greater) begin
					// shift the larger neighbor right, look one further left
					wdata = rdata;
					re    = (pos_q != ise_pkg::addr_t'(1));
					raddr = pos_q - ise_pkg::addr_t'(2);
				end else begin
					// key settles here, fetch the next key
					wdata = key_q;
					re    = more;
					raddr = i_q + ise_pkg::addr_t'(1);
				end
			end
			ise_pkg::ST_PLACE: begin
				we    = 1'b1;
				waddr = '0;
				wdata = key_q;
				re    = more;
				raddr = i_q + ise_pkg::addr_t'(1);
			end
			ise_pkg::ST_EMIT: begin
				re    = issue;
				raddr = e_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ise_pkg::ST_LOAD;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			i_q         <= '0;
			pos_q       <= '0;
			e_q         <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ise_pkg::ST_LOAD: begin
					if (accept) begin
						if (has_room) begin
							count_q <= count_q + ise_pkg::cnt_t'(1);
						end else begin
							dropped_q <= 1'b1;
						end
						if (items.last) begin
							i_q <= ise_pkg::addr_t'(1);
							e_q <= '0;
						end
					end
				end
				ise_pkg::ST_FIRST: begin
					pos_q <= i_q;
				end
				ise_pkg::ST_SCAN: begin
					if (greater) begin
						pos_q <= pos_q - ise_pkg::addr_t'(1);
					end else if (more) begin
						i_q <= i_q + ise_pkg::addr_t'(1);
					end
				end
				ise_pkg::ST_PLACE: begin
					if (more) begin
						i_q <= i_q + ise_pkg::addr_t'(1);
					end
				end
				ise_pkg::ST_EMIT: begin
					if (issue) begin
						pend_q <= 1'b1;
					end
					if (pend_q) begin
						pend_q <= 1'b0;
						e_q    <= e_q + ise_pkg::addr_t'(1);
						if (land_final) begin
							count_q   <= '0;
							dropped_q <= 1'b0;
						end
					end
				end
				default: begin
					pend_q <= 1'b0;
				end
			endcase

			if (pend_q) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// key and output payload
	always_ff @(posedge clk) begin
		if (state_q == ise_pkg::ST_FIRST) begin
			key_q <= rdata;
		end
		if (pend_q) begin
			sorted_q   <= rdata;
			final_q    <= land_final;
			overflow_q <= dropped_q;
		end
	end

`ifndef NO_ASSERTIONS
	// read-back data never lands on an occupied output register
	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !out_valid_q)
		else $error("read-back data lands on a full output register");

	// the hole stays inside the sorted prefix and never reaches entry zero
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ise_pkg::ST_SCAN) |-> (pos_q != '0 && pos_q <= i_q))
		else $error("insertion hole out of range");

	// count never passes the capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ise_pkg::cnt_t'(ise_pkg::CAPACITY))
		else $error("element count beyond capacity");

	// the final result closes the set and reopens loading
	a_set_close: assert property (@(posedge clk) disable iff (!arst_n)
		land_final |=> (state_q == ise_pkg::ST_LOAD && count_q == '0 && !dropped_q))
		else $error("set not closed after final result");

	// sorting only runs on sets of two or more values
	a_sort_size: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ise_pkg::ST_KEY) |-> (count_q >= ise_pkg::cnt_t'(2)))
		else $error("sort started on a set shorter than two");
`endif

endmodule

/* test/insertion_sort_engine_tb.sv */
// ----------------------------------------------------------------------------
// insertion_sort_engine_tb
// self-checking bench for the insertion sort engine
// ----------------------------------------------------------------------------
// Sends sets of signed values over the items channel and keeps a sorted
// copy of every set in a scoreboard. Each transaction on the results channel
// is checked in order against that copy: value, final flag and overflow flag.
// A short hand-written part covers single values, the signed extremes, equal
// values, presorted and reversed sets. Random sets follow: mostly small ones,
// some exactly full and some past capacity. Both channels idle at random, and
// once the result side holds off for a long time so that the input backs up.
// ----------------------------------------------------------------------------
module insertion_sort_engine_tb;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 3;
	localparam int RANDOM_ITEMS = 400;
	localparam int HOLD_CYCLES  = 600;
	// idle limit covers a full sort of a 64 entry set, plus the hold
	localparam int IDLE_LIMIT   = 20000;
	localparam int DRAIN_CYCLES = 16;

	typedef enum int {
		VAL_WIDE,
		VAL_CLUSTERED,
		VAL_EXTREME
	} value_style_t;

	typedef struct {
		ise_pkg::data_t sorted_value;
		logic           final_res;
		logic           overflow;
	} sort_result_t;

	class sort_scoreboard;
		ise_pkg::data_t held[$];
		bit             dropped;
		sort_result_t   ordered_q[$];
		int             errors;
		int             sets_done;
		int             overflow_sets;
		int             results_seen;

		// an accepted item: store or drop it, and on the last one sort the set
		function void note_item(ise_pkg::data_t v, logic l);
			ise_pkg::data_t ordered[$];
			ise_pkg::data_t key;
			int             j;
			sort_result_t   r;
			if (held.size() < ise_pkg::CAPACITY)
				held.push_back(v);
			else
				dropped = 1'b1;
			if (!l)
				return;
			ordered = held;
			for (int i = 1; i < ordered.size(); i++) begin
				key = ordered[i];
				j = i;
				while (j > 0 && ordered[j-1] > key) begin
					ordered[j] = ordered[j-1];
					j--;
				end
				ordered[j] = key;
			end
			foreach (ordered[k]) begin
				r.sorted_value = ordered[k];
				r.final_res    = (k == ordered.size() - 1);
				r.overflow     = dropped;
				ordered_q.push_back(r);
			end
			sets_done++;
			if (dropped)
				overflow_sets++;
			held.delete();
			dropped = 1'b0;
		endfunction

		function void check_result(ise_pkg::data_t v, logic f, logic o);
			sort_result_t r;
			results_seen++;
			if (ordered_q.size() == 0) begin
				$error("result with nothing pending: sorted_value %0d", v);
				errors++;
				return;
			end
			r = ordered_q.pop_front();
			if (v !== r.sorted_value) begin
				$error("sorted_value: expected %0d, actual %0d", r.sorted_value, v);
				errors++;
			end
			if (f !== r.final_res) begin
				$error("final_res: expected %0b, actual %0b", r.final_res, f);
				errors++;
			end
			if (o !== r.overflow) begin
				$error("overflow: expected %0b, actual %0b", r.overflow, o);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	ise_item_if   items_if();
	ise_result_if results_if();

	insertion_sort_engine DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if)
	);

	always #HALF_PERIOD clk = ~clk;

	sort_scoreboard sb = new();

	bit             quiet;          // no gaps on either side while set
	bit             hold_request;   // asks the result side for one long hold-off
	int             hold_left;
	int             stall_left;
	int             idle_cycles;
	int             items_sent;
	ise_pkg::data_t set_vals[$];

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic ise_pkg::data_t pick_value(value_style_t style);
		case (style)
			VAL_CLUSTERED: return ise_pkg::data_t'(int'($urandom_range(0, 15)) - 8);
			VAL_EXTREME: begin
				case ($urandom_range(0, 4))
					0:       return 32'sh7FFF_FFFF;
					1:       return 32'sh8000_0000;
					2:       return -32'sd1;
					3:       return 32'sd0;
					default: return 32'sd1;
				endcase
			end
			default: return ise_pkg::data_t'($urandom);
		endcase
	endfunction

	// one transaction on the items channel; valid stays up if no gap follows
	task automatic send_item(input ise_pkg::data_t v, input logic l);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			items_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_if.valid <= 1'b1;
		items_if.value <= v;
		items_if.last  <= l;
		do begin
			@(posedge clk);
		end while (!(items_if.valid && items_if.ready));
		sb.note_item(v, l);
		items_sent++;
	endtask

	// sends set_vals as one set, last on the final element
	task automatic send_set();
		foreach (set_vals[i])
			send_item(set_vals[i], i == set_vals.size() - 1);
		set_vals.delete();
	endtask

	task automatic build_set(input int n, input value_style_t style);
		set_vals.delete();
		repeat (n) set_vals.push_back(pick_value(style));
	endtask

	// result side: check every transaction, then pick ready for the next cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (results_if.valid && results_if.ready)
				sb.check_result(results_if.sorted_value, results_if.final_res,
					results_if.overflow);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				results_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				results_if.ready <= 1'b0;
			end else begin
				stall_left = pick_gap();
				results_if.ready <= 1'b1;
			end
		end else begin
			results_if.ready <= 1'b0;
		end
	end

	// watchdog: ends the run when neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (items_if.valid && items_if.ready)
				|| (results_if.valid && results_if.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int           random_start;
		int           rand_sets;
		int           n;
		int           r;
		value_style_t style;

		arst_n           <= 1'b0;
		items_if.valid   <= 1'b0;
		items_if.value   <= '0;
		items_if.last    <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single element sets at both signed extremes
		set_vals = {32'sh7FFF_FFFF};
		send_set();
		set_vals = {32'sh8000_0000};
		send_set();
		// two elements out of order, max before min
		set_vals = {32'sh7FFF_FFFF, 32'sh8000_0000};
		send_set();
		// values around zero mixed with the extremes
		set_vals = {32'sd1, -32'sd1, 32'sd0, 32'sh8000_0000, 32'sh7FFF_FFFF};
		send_set();
		// all elements equal
		set_vals = {-32'sd5, -32'sd5, -32'sd5, -32'sd5};
		send_set();
		// already ascending, then strictly descending (longest walk per key)
		set_vals = {-32'sd300, -32'sd2, 32'sd0, 32'sd7, 32'sd4096, 32'sd70000};
		send_set();
		set_vals = {32'sd900000, 32'sd12, 32'sd3, -32'sd3, -32'sd12, -32'sd900000};
		send_set();

		// random sets; the first few are forced to full, overfull and the hold-off
		random_start = items_sent;
		rand_sets = 0;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			quiet = ($urandom_range(0, 5) == 0);
			r = $urandom_range(0, 99);
			style = (r < 60) ? VAL_WIDE : (r < 85) ? VAL_CLUSTERED : VAL_EXTREME;
			case (rand_sets)
				0: n = ise_pkg::CAPACITY;
				1: n = ise_pkg::CAPACITY + 1;
				2: begin
					// results of this set get stuck behind a long hold-off
					n = 8;
					hold_request = 1'b1;
				end
				3: begin
					// offered back to back while the result side is still held
					n = ise_pkg::CAPACITY + 6;
					quiet = 1'b1;
				end
				default: begin
					r = $urandom_range(0, 99);
					if (r < 70)
						n = $urandom_range(1, 12);
					else if (r < 85)
						n = $urandom_range(13, 40);
					else if (r < 93)
						n = ise_pkg::CAPACITY;
					else
						n = $urandom_range(ise_pkg::CAPACITY + 1, ise_pkg::CAPACITY + 6);
				end
			endcase
			build_set(n, style);
			send_set();
			rand_sets++;
		end
		quiet = 1'b0;
		items_if.valid <= 1'b0;

		// wait for every sorted result, then drain for stray ones
		while (sb.ordered_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d sets (%0d past capacity) from %0d items",
			sb.sets_done, sb.overflow_sets, items_sent);
		$display("checked %0d sorted results, %0d mismatches", sb.results_seen, sb.errors);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
